// File: rtl/core/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg
// Shared constants for the segment volume envelope: command codes, field
// widths and limits of the segment definition.
// ----------------------------------------------------------------------------
package sve_pkg;

	// item field widths
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 4;
	localparam int DUR_W  = 16;
	localparam int TGT_W  = 7;
	localparam int LEN_W  = 6;
	localparam int VOL_W  = 23;
	localparam int SEG_W  = 5;
	localparam int ENTRY_W = DUR_W + TGT_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	// definition limits
	localparam logic [LEN_W-1:0] MAX_WORDS = 6'd32;
	localparam logic [LEN_W-1:0] MIN_WORDS = 6'd2;
	localparam logic [TGT_W-1:0] LEVEL_TOP = 7'd64;

endpackage

// File: rtl/core/segment_volume_envelope_unit.sv
// ----------------------------------------------------------------------------
// segment_volume_envelope_unit
// Sequence: load, idle, unused, short start and a tick within a segment or
// at the end of the definition go from accept straight to ST_DONE; a start
// or segment change that reads a zero duration passes ST_READ first; one
// that arms a segment passes ST_READ and the bit-serial divider in ST_DIV.
// Throughput: one item in flight at a time; the result register lets the
// next item be taken while a result waits. Reset clears all envelope state;
// the segment table holds no reset value until it is loaded.
// ----------------------------------------------------------------------------
module segment_volume_envelope_unit #(
	parameter int MAX_SEGMENTS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sve_pkg::CMD_W-1:0]   command,
	input  logic [sve_pkg::IDX_W-1:0]   seg_index,
	input  logic [sve_pkg::DUR_W-1:0]   seg_duration,
	input  logic [sve_pkg::TGT_W-1:0]   seg_target,
	input  logic [sve_pkg::LEN_W-1:0]   length_words,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sve_pkg::VOL_W-1:0]   volume_fixed,
	output logic [sve_pkg::TGT_W-1:0]   volume_level,
	output logic                        running,
	output logic [sve_pkg::SEG_W-1:0]   segment_now
);
	import sve_pkg::*;

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int LW = TGT_W + FRAC_BITS;      // volume width, Q7.F
	localparam int SW = LW + 1;                 // slope width, signed Q8.F
	localparam int CW = $clog2(LW + 1);         // divider step counter
	localparam logic [LW-1:0] TOP = {LEVEL_TOP, {FRAC_BITS{1'b0}}};

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]       state_q;
	logic             active_q;
	logic [SEG_W-1:0] ptr_q;
	logic [DUR_W-1:0] ticks_q;
	logic [LW-1:0]    level_q;
	logic [SW-1:0]    slope_q;
	logic [TGT_W-1:0] goal_q;
	logic [LEN_W-1:0] len_q;
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;

	logic             is_start_q;
	logic [DUR_W-1:0] rem_q;
	logic [LW-1:0]    quo_q;
	logic [DUR_W-1:0] div_q;
	logic             neg_q;
	logic [VOL_W-1:0] vol_fixed_q;
	logic [TGT_W-1:0] vol_level_q;
	logic             running_q;
	logic [SEG_W-1:0] seg_now_q;

	// segment table, synchronous read
	logic [ENTRY_W-1:0] seg_mem [MAX_SEGMENTS];
	logic [ENTRY_W-1:0] rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seg_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= seg_mem[mem_raddr];
		end
	end

	logic accept;
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	// load path: saturate target, drop out-of-range index
	logic [6:0]       idx_ext;
	logic [TGT_W-1:0] tgt_sat;
	assign idx_ext   = 7'(seg_index);
	assign tgt_sat   = (seg_target > LEVEL_TOP) ? LEVEL_TOP : seg_target;
	assign mem_we    = accept && (command == CMD_LOAD) && (idx_ext < 7'(MAX_SEGMENTS));
	assign mem_waddr = idx_ext[AW-1:0];
	assign mem_wdata = {seg_duration, tgt_sat};

	// start length clamp
	logic [LEN_W-1:0] len_clamp;
	assign len_clamp = (length_words > MAX_WORDS) ? MAX_WORDS : length_words;

	// tick: add slope and clamp to 0..64.0
	logic signed [LW+1:0] lvl_sum;
	logic [LW-1:0]        lvl_add;
	assign lvl_sum = $signed({2'b00, level_q}) + $signed({slope_q[SW-1], slope_q});
	always_comb begin
		if (lvl_sum < 0) begin
			lvl_add = '0;
		end else if (lvl_sum > $signed({2'b00, TOP})) begin
			lvl_add = TOP;
		end else begin
			lvl_add = lvl_sum[LW-1:0];
		end
	end

	// next segment after the current count runs out
	logic [SEG_W-1:0] ptr_inc;
	logic [6:0]       ptr_inc_ext;
	logic             def_end;
	logic             beyond_tab;
	assign ptr_inc     = ptr_q + SEG_W'(1);
	assign ptr_inc_ext = 7'(ptr_inc);
	assign def_end     = ({ptr_inc_ext[5:0], 1'b0} >= {1'b0, len_q});
	assign beyond_tab  = (ptr_inc_ext >= 7'(MAX_SEGMENTS));

	// memory read on start or segment change
	logic tick_arm;
	assign tick_arm = accept && (command == CMD_TICK) && active_q && (ticks_q <= DUR_W'(1))
	                  && !def_end && !beyond_tab;
	assign mem_re    = (accept && (command == CMD_START) && (len_clamp >= MIN_WORDS)) || tick_arm;
	assign mem_raddr = (command == CMD_START) ? '0 : ptr_inc_ext[AW-1:0];

	// arm: target of this segment, missing odd trailing target reads as zero
	logic [6:0]           ptr_ext;
	logic [DUR_W-1:0]     rd_dur;
	logic [TGT_W-1:0]     rd_tgt;
	logic signed [LW:0]   diff;
	logic [LW-1:0]        mag;
	assign ptr_ext = 7'(ptr_q);
	assign rd_dur  = rd_q[ENTRY_W-1:TGT_W];
	assign rd_tgt  = ({ptr_ext[5:0], 1'b1} >= {1'b0, len_q}) ? '0 : rd_q[TGT_W-1:0];
	assign diff    = $signed({1'b0, rd_tgt, {FRAC_BITS{1'b0}}}) - $signed({1'b0, level_q});
	assign mag     = diff[LW] ? LW'(-diff) : diff[LW-1:0];

	// restoring divider step
	logic [DUR_W:0]   trial;
	logic             fits;
	logic [DUR_W:0]   trial_sub;
	logic [DUR_W-1:0] rem_nxt;
	logic [LW-1:0]    quo_nxt;
	logic [SW-1:0]    quo_pos;
	assign trial     = {rem_q, quo_q[LW-1]};
	assign fits      = (trial >= {1'b0, div_q});
	assign trial_sub = trial - {1'b0, div_q};
	assign rem_nxt   = fits ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
	assign quo_nxt   = {quo_q[LW-2:0], fits};
	assign quo_pos   = {1'b0, quo_nxt};

	// result view of the state
	logic [30:0] lvl_ext;
	logic        out_load;
	assign lvl_ext  = 31'(level_q);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// control and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			ptr_q       <= '0;
			ticks_q     <= '0;
			level_q     <= '0;
			slope_q     <= '0;
			goal_q      <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						if (command == CMD_START) begin
							len_q    <= len_clamp;
							active_q <= 1'b1;
							ptr_q    <= '0;
							ticks_q  <= '0;
							level_q  <= '0;
							slope_q  <= '0;
							goal_q   <= '0;
							if (len_clamp >= MIN_WORDS) begin
								state_q <= ST_READ;
							end
						end else if (command == CMD_TICK && active_q) begin
							if (ticks_q > DUR_W'(1)) begin
								ticks_q <= ticks_q - DUR_W'(1);
								level_q <= lvl_add;
							end else begin
								ticks_q <= '0;
								level_q <= {goal_q, {FRAC_BITS{1'b0}}};
								ptr_q   <= ptr_inc;
								if (def_end || beyond_tab) begin
									active_q <= 1'b0;
								end else begin
									state_q <= ST_READ;
								end
							end
						end
					end
				end
				ST_READ: begin
					if (rd_dur == '0) begin
						// a zero duration stops a running envelope; a start stays idle-armed
						if (!is_start_q) begin
							active_q <= 1'b0;
						end
						state_q <= ST_DONE;
					end else begin
						goal_q  <= rd_tgt;
						ticks_q <= rd_dur;
						cnt_q   <= CW'(LW);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						slope_q <= neg_q ? -quo_pos : quo_pos;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			is_start_q <= (command == CMD_START);
		end
		if (state_q == ST_READ) begin
			rem_q <= '0;
			quo_q <= mag;
			div_q <= rd_dur;
			neg_q <= diff[LW];
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
		if (out_load) begin
			vol_fixed_q <= lvl_ext[VOL_W-1:0];
			vol_level_q <= level_q[LW-1:FRAC_BITS];
			running_q   <= active_q;
			seg_now_q   <= ptr_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign volume_fixed = vol_fixed_q;
	assign volume_level = vol_level_q;
	assign running      = running_q;
	assign segment_now  = seg_now_q;

endmodule
